// ----- rtl/gcfl_pkg.sv -----
// shared constants, codes and port bundles of the grouped channel free-list allocator
package gcfl_pkg;

  localparam int CHANNELS = 64;
  localparam int CH_W     = $clog2(CHANNELS);
  localparam int GROUPS   = 4;
  localparam int GRP_W    = $clog2(GROUPS);
  localparam int CNT_W    = CH_W + 1;
  localparam int OWN_W    = 3;
  localparam int SPAN_RST = CHANNELS / GROUPS;

  localparam logic [OWN_W-1:0] NO_OWNER = 3'd7;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_FREE    = 2'd1,
    CMD_QUERY   = 2'd2,
    CMD_REBUILD = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_BAD_GROUP = 2'd1,
    STS_EMPTY     = 2'd2,
    STS_NOT_ALLOC = 2'd3
  } status_t;

  typedef logic [CH_W-1:0]  chan_t;
  typedef logic [CNT_W-1:0] count_t;
  typedef logic [OWN_W-1:0] owner_t;

  typedef chan_t  span_start_t [GROUPS];
  typedef count_t span_count_t [GROUPS];

  // channel table access for one cycle
  typedef struct packed {
    logic   link_we;
    chan_t  link_waddr;
    chan_t  link_wdata;
    logic   link_re;
    chan_t  link_raddr;
    logic   own_we;
    chan_t  own_waddr;
    owner_t own_wdata;
    logic   use_we;
    chan_t  use_waddr;
    logic   use_wdata;
    logic   chan_re;
    chan_t  chan_raddr;
  } tbl_req_t;

  typedef struct packed {
    chan_t  link;
    owner_t owner;
    logic   used;
  } tbl_rsp_t;

endpackage

// ----- rtl/gcfl_span_decode.sv -----
// span compare unit: owning group of one channel under the snapshot spans
module gcfl_span_decode import gcfl_pkg::*; (
  input  chan_t       chan,
  input  span_start_t span_start,
  input  span_count_t span_count,
  output owner_t      owner
);

  logic [CNT_W:0] span_end [GROUPS];

  always_comb begin
    owner = NO_OWNER;
    // highest first so the lowest-numbered group claims an overlap
    for (int g = GROUPS - 1; g >= 0; g--) begin
      span_end[g] = {2'b00, span_start[g]} + {1'b0, span_count[g]};
      if (chan >= span_start[g] && {2'b00, chan} < span_end[g]) begin
        owner = OWN_W'(g);
      end
    end
  end

endmodule

// ----- rtl/gcfl_chan_table.sv -----
// per-channel storage: link, owner and allocated flag, registered reads
module gcfl_chan_table import gcfl_pkg::*; (
  input  logic     clk,
  input  tbl_req_t req,
  output tbl_rsp_t rsp
);

  chan_t  link_mem  [CHANNELS];
  owner_t owner_mem [CHANNELS];
  logic   used_mem  [CHANNELS];

  // one process owns the whole response register
  always_ff @(posedge clk) begin
    if (req.link_we) begin
      link_mem[req.link_waddr] <= req.link_wdata;
    end
    if (req.link_re) begin
      rsp.link <= link_mem[req.link_raddr];
    end
    if (req.own_we) begin
      owner_mem[req.own_waddr] <= req.own_wdata;
    end
    if (req.use_we) begin
      used_mem[req.use_waddr] <= req.use_wdata;
    end
    if (req.chan_re) begin
      rsp.owner <= owner_mem[req.chan_raddr];
      rsp.used  <= used_mem[req.chan_raddr];
    end
  end

endmodule

// ----- rtl/grouped_channel_free_list_allocator_top.sv -----
// top level of the grouped channel free-list allocator
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------------------
//  in      | input     | in_valid / in_stall    | cmd, group_number, channel_number
//  out     | output    | out_valid / out_stall  | status, granted_channel, idle_count
//  cfg     | input     | cfg_valid / cfg_ready  | cfg_index (register 0..7), cfg_data
//
//  alloc, free and query run as accept (table read issued), then execute
//  rebuild: the span compare unit walks one channel a cycle, then the reply executes
//  after reset the same walk runs over every channel before the first item is taken
//  execute waits while the output register holds a result that is stalled
//  cfg_ready is always high; spans are sampled when a rebuild or the reset walk starts
module grouped_channel_free_list_allocator_top import gcfl_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  // item input
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [1:0]   cmd,
  input  logic [2:0]   group_number,
  input  logic [5:0]   channel_number,
  // result output
  output logic         out_valid,
  input  logic         out_stall,
  output logic [1:0]   status,
  output logic [5:0]   granted_channel,
  output logic [6:0]   idle_count,
  // register writes
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [6:0]   cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_EXEC  = 3'b010,
    ST_SWEEP = 3'b100
  } state_t;

  state_t state;

  // configuration registers and the span snapshot used by the walk
  span_start_t cfg_start;
  span_count_t cfg_count;
  span_start_t span_start;
  span_count_t span_count;

  // per-group list control
  chan_t  list_head  [GROUPS];
  chan_t  list_tail  [GROUPS];
  count_t free_total [GROUPS];

  // captured item
  cmd_t              cmd_q;
  logic [2:0]        grp_q;
  chan_t             ch_q;

  chan_t  sweep_idx;
  logic   sweep_reply;
  owner_t sweep_owner;

  tbl_req_t tbl_req;
  tbl_rsp_t tbl_rsp;

  logic             in_accept;
  logic             out_free;
  logic             out_load;
  logic             push_en;
  logic [GRP_W-1:0] push_g;
  chan_t            push_ch;
  logic             pop_en;
  logic [GRP_W-1:0] pop_g;
  status_t          res_status;
  chan_t            res_grant;
  count_t           res_idle;
  logic [GRP_W-1:0] g_q;
  logic             grp_bad;
  logic [GRP_W-1:0] own_g;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  assign g_q     = grp_q[GRP_W-1:0];
  assign grp_bad = (grp_q >= 3'(GROUPS));
  assign own_g   = tbl_rsp.owner[GRP_W-1:0];

  // the shared compare unit, stepped over every channel during a walk
  gcfl_span_decode u_span (
    .chan       (sweep_idx),
    .span_start (span_start),
    .span_count (span_count),
    .owner      (sweep_owner)
  );

  gcfl_chan_table u_table (
    .clk (clk),
    .req (tbl_req),
    .rsp (tbl_rsp)
  );

  always_comb begin
    tbl_req    = '0;
    push_en    = 1'b0;
    push_g     = '0;
    push_ch    = '0;
    pop_en     = 1'b0;
    pop_g      = '0;
    out_load   = 1'b0;
    res_status = STS_OK;
    res_grant  = '0;
    res_idle   = '0;

    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          // fetch the successor of the head and the channel's owner and flag
          tbl_req.link_re    = 1'b1;
          tbl_req.link_raddr = list_head[group_number[GRP_W-1:0]];
          tbl_req.chan_re    = 1'b1;
          tbl_req.chan_raddr = channel_number;
        end
      end
      ST_SWEEP: begin
        tbl_req.own_we    = 1'b1;
        tbl_req.own_waddr = sweep_idx;
        tbl_req.own_wdata = sweep_owner;
        tbl_req.use_we    = 1'b1;
        tbl_req.use_waddr = sweep_idx;
        tbl_req.use_wdata = 1'b0;
        if (sweep_owner < OWN_W'(GROUPS)) begin
          push_en = 1'b1;
          push_g  = sweep_owner[GRP_W-1:0];
          push_ch = sweep_idx;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          out_load = 1'b1;
          case (cmd_q)
            CMD_ALLOC: begin
              if (grp_bad) begin
                res_status = STS_BAD_GROUP;
              end else if (free_total[g_q] == '0) begin
                res_status = STS_EMPTY;
              end else begin
                pop_en            = 1'b1;
                pop_g             = g_q;
                res_grant         = list_head[g_q];
                res_idle          = free_total[g_q] - CNT_W'(1);
                tbl_req.use_we    = 1'b1;
                tbl_req.use_waddr = list_head[g_q];
                tbl_req.use_wdata = 1'b1;
              end
            end
            CMD_FREE: begin
              if (tbl_rsp.owner >= OWN_W'(GROUPS)) begin
                res_status = STS_NOT_ALLOC;
              end else if (!tbl_rsp.used) begin
                res_status = STS_NOT_ALLOC;
                res_idle   = free_total[own_g];
              end else begin
                push_en           = 1'b1;
                push_g            = own_g;
                push_ch           = ch_q;
                res_idle          = free_total[own_g] + CNT_W'(1);
                tbl_req.use_we    = 1'b1;
                tbl_req.use_waddr = ch_q;
                tbl_req.use_wdata = 1'b0;
              end
            end
            default: begin
              // query, and the reply after a rebuild walk
              if (grp_bad) begin
                res_status = STS_BAD_GROUP;
              end else begin
                res_idle = free_total[g_q];
              end
            end
          endcase
        end
      end
      default: begin
      end
    endcase

    // tail append: link the old tail only when the list is not empty
    if (push_en && free_total[push_g] != '0) begin
      tbl_req.link_we    = 1'b1;
      tbl_req.link_waddr = list_tail[push_g];
      tbl_req.link_wdata = push_ch;
    end
  end

  // register file writes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int g = 0; g < GROUPS; g++) begin
        cfg_start[g] <= CH_W'(g * SPAN_RST);
        cfg_count[g] <= CNT_W'(SPAN_RST);
      end
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index[0]) begin
        cfg_count[cfg_index[2:1]] <= cfg_data;
      end else begin
        cfg_start[cfg_index[2:1]] <= cfg_data[CH_W-1:0];
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_SWEEP;
      sweep_idx   <= '0;
      sweep_reply <= 1'b0;
      for (int g = 0; g < GROUPS; g++) begin
        span_start[g] <= CH_W'(g * SPAN_RST);
        span_count[g] <= CNT_W'(SPAN_RST);
      end
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_accept) begin
            if (cmd_t'(cmd) == CMD_REBUILD) begin
              state       <= ST_SWEEP;
              sweep_idx   <= '0;
              sweep_reply <= 1'b1;
              span_start  <= cfg_start;
              span_count  <= cfg_count;
            end else begin
              state <= ST_EXEC;
            end
          end
        end
        ST_SWEEP: begin
          sweep_idx <= sweep_idx + CH_W'(1);
          if (sweep_idx == CH_W'(CHANNELS - 1)) begin
            state <= sweep_reply ? ST_EXEC : ST_IDLE;
          end
        end
        ST_EXEC: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_q <= cmd_t'(cmd);
      grp_q <= group_number;
      ch_q  <= channel_number;
    end
  end

  // list heads, tails and free counts
  always_ff @(posedge clk) begin
    if (rst || (in_accept && cmd_t'(cmd) == CMD_REBUILD)) begin
      for (int g = 0; g < GROUPS; g++) begin
        list_head[g]  <= '0;
        list_tail[g]  <= '0;
        free_total[g] <= '0;
      end
    end else begin
      if (push_en) begin
        if (free_total[push_g] == '0) begin
          list_head[push_g] <= push_ch;
        end
        list_tail[push_g]  <= push_ch;
        free_total[push_g] <= free_total[push_g] + CNT_W'(1);
      end
      if (pop_en) begin
        list_head[pop_g]  <= tbl_rsp.link;
        free_total[pop_g] <= free_total[pop_g] - CNT_W'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status          <= res_status;
      granted_channel <= res_grant;
      idle_count      <= res_idle;
    end
  end

  // a free count never passes the number of channels
  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    free_total[0] <= CNT_W'(CHANNELS) && free_total[1] <= CNT_W'(CHANNELS) &&
    free_total[2] <= CNT_W'(CHANNELS) && free_total[3] <= CNT_W'(CHANNELS))
    else $error("free count above channel count");

  // a new result only ever comes out of the execute step
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    (out_load == 1'b0 && !(out_valid && out_stall)) |=> !out_valid)
    else $error("result appeared without execute");

  // a refused item never hands out a channel number
  a_grant_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != STS_OK) |-> granted_channel == '0)
    else $error("channel granted by a refused item");

  // an accepted item blocks the input for at least the next cycle
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> in_stall)
    else $error("second item taken while one is at work");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// self-checking bench for the grouped channel free-list allocator, with its own allocator predictor
module testbench;
  import gcfl_pkg::*;

  // span register map: start and count of each group, interleaved
  typedef enum logic [2:0] {
    REG_G0_START, REG_G0_COUNT, REG_G1_START, REG_G1_COUNT,
    REG_G2_START, REG_G2_COUNT, REG_G3_START, REG_G3_COUNT
  } reg_idx_t;

  localparam int NUM_REGS         = 2 * GROUPS;
  localparam int RANDOM_PER_PHASE = 275;
  localparam int HOLD_CYCLES      = 300;
  localparam int CYCLE_LIMIT      = 400000;

  typedef struct packed {
    status_t status;
    chan_t   granted;
    count_t  idle;
  } reply_t;

  // one row of the directed table; spans >= 0 loads a span set and drains first
  typedef struct packed {
    int          spans;
    cmd_t        op;
    logic [2:0]  grp;
    chan_t       ch;
    bit          typed;
    reply_t      reply;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] cmd = '0;
  logic [2:0] group_number = '0;
  logic [5:0] channel_number = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] status;
  logic [5:0] granted_channel;
  logic [6:0] idle_count;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [6:0] cfg_data = '0;

  grouped_channel_free_list_allocator_top i_dut (.*);

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // allocator predictor: its own copy of the channel table and register file
  // ---------------------------------------------------------------------------
  logic [6:0] reg_file   [NUM_REGS];
  chan_t      link_mem   [CHANNELS];
  owner_t     chan_owner [CHANNELS];
  bit         chan_busy  [CHANNELS];
  chan_t      idle_head  [GROUPS];
  chan_t      idle_tail  [GROUPS];
  count_t     idle_total [GROUPS];

  reply_t awaited_replies [$];

  int fail_count    = 0;
  int items_sent    = 0;
  int grants_seen   = 0;
  int returns_seen  = 0;
  int rebuilds_seen = 0;
  int refusals_seen = 0;
  int span_loads    = 0;

  // channel joins the tail of its group's idle fifo
  function automatic void append_idle(int g, chan_t ch);
    if (idle_total[g] == 0) idle_head[g] = ch;
    else link_mem[idle_tail[g]] = ch;
    idle_tail[g] = ch;
    link_mem[ch] = ch;
    idle_total[g] = idle_total[g] + 1'b1;
  endfunction

  // every channel goes idle; lower groups win overlapping channels, spans clip at the top
  function automatic void rebuild_lists();
    int first, last;
    for (int c = 0; c < CHANNELS; c++) begin
      link_mem[c]   = '0;
      chan_owner[c] = NO_OWNER;
      chan_busy[c]  = 1'b0;
    end
    for (int g = 0; g < GROUPS; g++) begin
      idle_head[g]  = '0;
      idle_tail[g]  = '0;
      idle_total[g] = '0;
      first = int'(reg_file[REG_G0_START + 2 * g][CH_W-1:0]);
      last  = first + int'(reg_file[REG_G0_COUNT + 2 * g]);
      if (last > CHANNELS) last = CHANNELS;
      for (int c = first; c < last; c++) begin
        if (chan_owner[c] == NO_OWNER) begin
          chan_owner[c] = owner_t'(g);
          append_idle(g, chan_t'(c));
        end
      end
    end
  endfunction

  function automatic void reset_model();
    for (int g = 0; g < GROUPS; g++) begin
      reg_file[REG_G0_START + 2 * g] = 7'(SPAN_RST * g);
      reg_file[REG_G0_COUNT + 2 * g] = 7'(SPAN_RST);
    end
    rebuild_lists();
  endfunction

  function automatic void store_register(reg_idx_t idx, logic [6:0] value);
    reg_file[idx] = idx[0] ? value : {1'b0, value[CH_W-1:0]};
  endfunction

  // outcome of one command, applied to the predictor's table
  function automatic reply_t compute_reply(cmd_t op, logic [2:0] grp, chan_t ch);
    reply_t r;
    int     own;
    int     g;
    chan_t  oldest;
    r   = '{STS_OK, '0, '0};
    own = int'(chan_owner[ch]);
    g   = int'(grp);
    if (op == CMD_FREE) begin
      if (own >= GROUPS) begin
        r.status = STS_NOT_ALLOC;
      end else if (!chan_busy[ch]) begin
        r.status = STS_NOT_ALLOC;
        r.idle   = idle_total[own];
      end else begin
        chan_busy[ch] = 1'b0;
        append_idle(own, ch);
        r.idle = idle_total[own];
      end
    end else begin
      if (op == CMD_REBUILD) rebuild_lists();
      if (g >= GROUPS) begin
        r.status = STS_BAD_GROUP;
      end else if (op == CMD_ALLOC) begin
        if (idle_total[g] == 0) begin
          r.status = STS_EMPTY;
        end else begin
          oldest            = idle_head[g];
          idle_head[g]      = link_mem[oldest];
          chan_busy[oldest] = 1'b1;
          idle_total[g]     = idle_total[g] - 1'b1;
          r.granted         = oldest;
          r.idle            = idle_total[g];
        end
      end else begin
        r.idle = idle_total[g];
      end
    end
    return r;
  endfunction

  function automatic int pick_busy_channel();
    int busy [$];
    for (int c = 0; c < CHANNELS; c++) if (chan_busy[c]) busy.push_back(c);
    if (busy.size() == 0) return -1;
    return busy[$urandom_range(busy.size() - 1)];
  endfunction

  // ---------------------------------------------------------------------------
  // idling knobs, shared by the sender and the receiver
  // ---------------------------------------------------------------------------
  int  sender_idle_pct   = 25;
  int  receiver_idle_pct = 48;
  bit  hold_req          = 1'b0;
  int  hold_left         = 0;

  // receiver: random stall per cycle, or one long hold-off counted down here
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_stall <= 1'b1;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < receiver_idle_pct);
      end
    end
  end

  // result checker: every transfer out is matched against the oldest expectation
  always @(posedge clk) begin
    reply_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (awaited_replies.size() == 0) begin
        $error("result with nothing expected: status %0d channel %0d count %0d",
               status, granted_channel, idle_count);
        fail_count++;
      end else begin
        exp_r = awaited_replies.pop_front();
        if (status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, status);
          fail_count++;
        end
        if (granted_channel !== exp_r.granted) begin
          $error("granted_channel: expected %0d, got %0d", exp_r.granted, granted_channel);
          fail_count++;
        end
        if (idle_count !== exp_r.idle) begin
          $error("idle_count: expected %0d, got %0d", exp_r.idle, idle_count);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  // offers one item, optionally after idle cycles; valid stays up after the transfer
  // so back-to-back items never drop it, quiet_input() lowers it
  task automatic send_item(cmd_t op, logic [2:0] grp, chan_t ch, bit typed, reply_t typed_r);
    reply_t r;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    cmd            <= op;
    group_number   <= grp;
    channel_number <= ch;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // transfer happened at this edge: predict with the table as it stands now
    r = compute_reply(op, grp, ch);
    awaited_replies.push_back(typed ? typed_r : r);
    items_sent++;
    case (op)
      CMD_ALLOC:   if (r.status == STS_OK) grants_seen++;
      CMD_FREE:    if (r.status == STS_OK) returns_seen++;
      CMD_REBUILD: rebuilds_seen++;
      default: ;
    endcase
    if (r.status != STS_OK) refusals_seen++;
  endtask

  // mostly well-formed traffic: allocs on live groups and returns of channels held,
  // with a minority of bad groups, stray returns, queries and the odd rebuild
  task automatic send_random_item();
    int         pick;
    int         held;
    cmd_t       op;
    logic [2:0] grp;
    chan_t      ch;
    pick = $urandom_range(99);
    grp  = ($urandom_range(9) == 0) ? 3'($urandom_range(7, GROUPS))
                                    : 3'($urandom_range(GROUPS - 1));
    ch   = chan_t'($urandom_range(CHANNELS - 1));
    if (pick < 42) begin
      op = CMD_ALLOC;
    end else if (pick < 80) begin
      op   = CMD_FREE;
      held = pick_busy_channel();
      if (held >= 0 && $urandom_range(9) != 0) ch = chan_t'(held);
    end else if (pick < 97) begin
      op = CMD_QUERY;
    end else begin
      op = CMD_REBUILD;
    end
    send_item(op, grp, ch, 1'b0, '0);
  endtask

  task automatic quiet_input();
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (awaited_replies.size() > 0) @(posedge clk);
  endtask

  // span register writes; only issued with the input quiet and nothing in flight
  logic [6:0] span_plan [NUM_REGS];

  task automatic program_spans();
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= reg_idx_t'(i);
      cfg_data  <= span_plan[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      store_register(reg_idx_t'(i), span_plan[i]);
    end
    cfg_valid <= 1'b0;
    span_loads++;
  endtask

  // tiled spans for deep alloc/free traffic, or free-form spans with overlap and clipping
  task automatic plan_spans(int phase);
    int next_start, first, len;
    next_start = 0;
    for (int g = 0; g < GROUPS; g++) begin
      if (phase == 1) begin
        first = $urandom_range(CHANNELS - 1);
        case ($urandom_range(3))
          0:       len = 0;
          1:       len = CHANNELS;
          default: len = $urandom_range(1, 24);
        endcase
      end else begin
        len        = $urandom_range(1, (phase == 0) ? 16 : 6);
        first      = next_start;
        next_start = next_start + len;
      end
      span_plan[REG_G0_START + 2 * g] = 7'(first);
      span_plan[REG_G0_COUNT + 2 * g] = 7'(len);
    end
  endtask

  // ---------------------------------------------------------------------------
  // directed table
  //   span set 0: group zero covers everything, group one overlaps it, group two
  //               starts on the last channel and runs past the end, group three empty
  //   span set 1: group zero empty, group one clipped at the top, group two from
  //               channel zero, group three fully overlapped by group one
  // ---------------------------------------------------------------------------
  logic [6:0] span_sets [2][NUM_REGS] = '{
    '{7'd0, 7'd64, 7'd10, 7'd5,  7'd63, 7'd64, 7'd63, 7'd0},
    '{7'd0, 7'd0,  7'd40, 7'd30, 7'd0,  7'd40, 7'd63, 7'd1}
  };

  localparam int DIR_ROWS = 25;

  dir_row_t directed_rows [DIR_ROWS] = '{
    // reset layout: four spans of sixteen
    '{-1, CMD_QUERY,   3'd0, 6'd0,  1'b1, '{STS_OK,        6'd0,  7'd16}},
    '{-1, CMD_QUERY,   3'd7, 6'd63, 1'b1, '{STS_BAD_GROUP, 6'd0,  7'd0}},
    '{-1, CMD_ALLOC,   3'd4, 6'd0,  1'b1, '{STS_BAD_GROUP, 6'd0,  7'd0}},
    '{-1, CMD_ALLOC,   3'd0, 6'd0,  1'b1, '{STS_OK,        6'd0,  7'd15}},
    '{-1, CMD_ALLOC,   3'd3, 6'd0,  1'b1, '{STS_OK,        6'd48, 7'd15}},
    '{-1, CMD_FREE,    3'd0, 6'd63, 1'b1, '{STS_NOT_ALLOC, 6'd0,  7'd15}},
    '{-1, CMD_FREE,    3'd0, 6'd48, 1'b1, '{STS_OK,        6'd0,  7'd16}},
    '{-1, CMD_FREE,    3'd0, 6'd48, 1'b1, '{STS_NOT_ALLOC, 6'd0,  7'd16}},
    '{-1, CMD_FREE,    3'd7, 6'd0,  1'b1, '{STS_OK,        6'd0,  7'd16}},
    // returned channel went to the tail, so the next one up is handed out
    '{-1, CMD_ALLOC,   3'd0, 6'd0,  1'b0, '0},
    '{-1, CMD_REBUILD, 3'd2, 6'd0,  1'b1, '{STS_OK,        6'd0,  7'd16}},
    '{-1, CMD_REBUILD, 3'd5, 6'd0,  1'b1, '{STS_BAD_GROUP, 6'd0,  7'd0}},
    // span set 0
    '{ 0, CMD_REBUILD, 3'd0, 6'd0,  1'b1, '{STS_OK,        6'd0,  7'd64}},
    '{-1, CMD_ALLOC,   3'd1, 6'd0,  1'b1, '{STS_EMPTY,     6'd0,  7'd0}},
    '{-1, CMD_ALLOC,   3'd3, 6'd0,  1'b1, '{STS_EMPTY,     6'd0,  7'd0}},
    '{-1, CMD_FREE,    3'd0, 6'd63, 1'b1, '{STS_NOT_ALLOC, 6'd0,  7'd64}},
    '{-1, CMD_ALLOC,   3'd0, 6'd0,  1'b1, '{STS_OK,        6'd0,  7'd63}},
    '{-1, CMD_QUERY,   3'd2, 6'd0,  1'b1, '{STS_OK,        6'd0,  7'd0}},
    // span set 1
    '{ 1, CMD_REBUILD, 3'd1, 6'd0,  1'b1, '{STS_OK,        6'd0,  7'd24}},
    '{-1, CMD_QUERY,   3'd2, 6'd0,  1'b1, '{STS_OK,        6'd0,  7'd40}},
    '{-1, CMD_QUERY,   3'd3, 6'd0,  1'b1, '{STS_OK,        6'd0,  7'd0}},
    '{-1, CMD_ALLOC,   3'd0, 6'd0,  1'b1, '{STS_EMPTY,     6'd0,  7'd0}},
    '{-1, CMD_FREE,    3'd0, 6'd5,  1'b1, '{STS_NOT_ALLOC, 6'd0,  7'd40}},
    '{-1, CMD_ALLOC,   3'd6, 6'd0,  1'b1, '{STS_BAD_GROUP, 6'd0,  7'd0}},
    '{-1, CMD_ALLOC,   3'd2, 6'd0,  1'b1, '{STS_OK,        6'd0,  7'd39}}
  };

  // watchdog: a hung handshake ends the run here
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Mismatches found");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    reset_model();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed rows, under the first idling mix; the reset walk is waited out by in_stall
    foreach (directed_rows[i]) begin
      if (directed_rows[i].spans >= 0) begin
        quiet_input();
        wait_drained();
        span_plan = span_sets[directed_rows[i].spans];
        program_spans();
      end
      send_item(directed_rows[i].op, directed_rows[i].grp, directed_rows[i].ch,
                directed_rows[i].typed, directed_rows[i].reply);
    end

    // random phases: sender-light, then receiver-light, then no idling with one hold-off
    for (int phase = 0; phase < 3; phase++) begin
      quiet_input();
      wait_drained();
      case (phase)
        0:       begin sender_idle_pct = 25; receiver_idle_pct = 48; end
        1:       begin sender_idle_pct = 48; receiver_idle_pct = 25; end
        default: begin sender_idle_pct = 0;  receiver_idle_pct = 0;  end
      endcase
      plan_spans(phase);
      program_spans();
      // new spans only count after a rebuild
      send_item(CMD_REBUILD, 3'($urandom_range(7)), chan_t'($urandom_range(CHANNELS - 1)),
                1'b0, '0);
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        // long receiver hold-off while items keep coming, so the input backs up
        if (phase == 2 && i == 100) hold_req = 1'b1;
        send_random_item();
      end
    end

    quiet_input();
    wait_drained();
    // room for a stray result after a full channel walk
    repeat (CHANNELS + 8) @(posedge clk);
    if (awaited_replies.size() != 0) begin
      $error("%0d results never arrived", awaited_replies.size());
      fail_count++;
    end

    $display("run covered %0d items: %0d grants, %0d returns, %0d rebuilds, %0d refused",
             items_sent, grants_seen, returns_seen, rebuilds_seen, refusals_seen);
    $display("%0d span register loads, one receiver hold-off of %0d cycles",
             span_loads, HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/gcfl_pkg.sv
rtl/gcfl_span_decode.sv
rtl/gcfl_chan_table.sv
rtl/grouped_channel_free_list_allocator_top.sv
tb/testbench.sv
